FILE: rtl/fircb_pkg.sv
`default_nettype none
package fircb_pkg;

  localparam int MAX_TAPS_DEF = 32;
  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;
  localparam int FRAC_BITS    = 15;
  localparam int TAP_CNT_W    = 6;
  localparam int COEF_IDX_W   = 5;
  localparam int OP_W         = 2;

  localparam logic [TAP_CNT_W-1:0] TAP_RESET = TAP_CNT_W'(32);

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_COEF  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [COEF_BITS-1:0]  coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_out;
    logic                          saturated;
  } out_item_t;

  typedef struct packed {
    logic acc_clr;
    logic prod_en;
    logic fin_en;
  } mac_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/fircb_ram.sv
`default_nettype none
module fircb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/fircb_mac.sv
`default_nettype none
module fircb_mac #(
  parameter int MAX_TAPS = fircb_pkg::MAX_TAPS_DEF,
  localparam int SB      = fircb_pkg::SAMPLE_BITS,
  localparam int CB      = fircb_pkg::COEF_BITS,
  localparam int FB      = fircb_pkg::FRAC_BITS,
  localparam int PROD_W  = SB + CB,
  localparam int ACC_W   = PROD_W + $clog2(MAX_TAPS) + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fircb_pkg::mac_ctl_t  ctl,
  input  wire logic signed [SB-1:0] smp,
  input  wire logic signed [CB-1:0] coef,
  output fircb_pkg::out_item_t      res_r
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-FB-SB:0]     upper;
  logic                     fits;
  fircb_pkg::out_item_t     res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.prod_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= smp * coef;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.fin_en) begin
      res_r <= res_nxt;
    end
  end

  // floor shift is a plain slice; clip when the result's sign bit and the bits above it differ
  always_comb begin
    upper = acc_r[ACC_W-1:FB+SB-1];
    fits  = (&upper) | ~(|upper);
    if (fits) begin
      res_nxt.filtered_out = acc_r[FB+SB-1:FB];
      res_nxt.saturated    = 1'b0;
    end else begin
      res_nxt.filtered_out = acc_r[ACC_W-1] ? {1'b1, {(SB-1){1'b0}}}
                                            : {1'b0, {(SB-1){1'b1}}};
      res_nxt.saturated    = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fir_filter_circular_buffer_core.sv
`default_nettype none
// Direct-form FIR filter, one shared multiply-accumulate unit.
// Push: MAC over taps slots (taps = tap_count held to 1..MAX_TAPS), then D1, D2, FIN, DONE;
//   busy until DONE, more while an earlier result waits. Coef write, clear: never busy.
// Reset (sync, active low): history and coefficients read as zero, write
//   position 0, tap_count 32. No clearing pass.
module fir_filter_circular_buffer_core #(
  parameter int MAX_TAPS = fircb_pkg::MAX_TAPS_DEF,
  localparam int SB      = fircb_pkg::SAMPLE_BITS,
  localparam int CB      = fircb_pkg::COEF_BITS,
  localparam int PTR_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int CNT_W   = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire fircb_pkg::in_item_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output fircb_pkg::out_item_t                 out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fircb_pkg::TAP_CNT_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_D1   = 3'd2;
  localparam logic [2:0] S_D2   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [fircb_pkg::TAP_CNT_W-1:0] tap_r;
  logic [PTR_W-1:0]                pos_r;
  logic [PTR_W-1:0]                slot_r, slot_nxt;
  logic [PTR_W-1:0]                idx_r, idx_nxt;
  logic [MAX_TAPS-1:0]             hist_vld_r;
  logic [MAX_TAPS-1:0]             coef_vld_r;
  logic                            rd_vld_r;
  logic                            hok_r;
  logic                            cok_r;
  logic                            out_valid_r;
  fircb_pkg::out_item_t            out_data_r;
  logic                            out_load;

  logic [31:0]                     tc32;
  logic [31:0]                     eff32;
  logic [31:0]                     cidx32;
  logic [CNT_W-1:0]                taps;
  logic [CNT_W-1:0]                taps_m1;
  logic [CNT_W-1:0]                pos_inc;
  logic [PTR_W-1:0]                pos_eff;
  logic [PTR_W-1:0]                pos_next;
  logic [PTR_W-1:0]                cidx;
  logic                            cidx_ok;
  logic                            last_tap;
  logic                            acc_push;
  logic                            acc_coef;
  logic                            acc_clear;

  logic [SB-1:0]                   hist_rdata;
  logic [CB-1:0]                   coef_rdata;
  logic signed [SB-1:0]            smp_op;
  logic signed [CB-1:0]            coef_op;
  fircb_pkg::mac_ctl_t             ctl;
  fircb_pkg::out_item_t            mac_res;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign acc_push  = in_valid && in_ready && (in_data.op == fircb_pkg::OP_PUSH);
  assign acc_coef  = in_valid && in_ready && (in_data.op == fircb_pkg::OP_COEF);
  assign acc_clear = in_valid && in_ready && (in_data.op == fircb_pkg::OP_CLEAR);

  always_comb begin
    tc32 = 32'(tap_r);
    if (tc32 == 32'd0) begin
      eff32 = 32'd1;
    end else if (tc32 > 32'(MAX_TAPS)) begin
      eff32 = 32'(MAX_TAPS);
    end else begin
      eff32 = tc32;
    end
    taps     = eff32[CNT_W-1:0];
    taps_m1  = taps - CNT_W'(1);
    pos_eff  = (CNT_W'(pos_r) < taps) ? pos_r : '0;
    pos_inc  = CNT_W'(pos_eff) + CNT_W'(1);
    pos_next = (pos_inc >= taps) ? '0 : pos_inc[PTR_W-1:0];
    cidx32   = 32'(in_data.coef_index);
    cidx     = cidx32[PTR_W-1:0];
    cidx_ok  = (cidx32 < 32'(MAX_TAPS));
    last_tap = ((CNT_W'(idx_r) + CNT_W'(1)) == taps);
  end

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    idx_nxt     = idx_r;
    out_load    = 1'b0;
    ctl.acc_clr = 1'b0;
    ctl.prod_en = rd_vld_r;
    ctl.fin_en  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc_push) begin
          state_nxt   = S_MAC;
          slot_nxt    = pos_eff;
          idx_nxt     = '0;
          ctl.acc_clr = 1'b1;
        end
      end
      S_MAC: begin
        slot_nxt = (slot_r == '0) ? taps_m1[PTR_W-1:0] : slot_r - PTR_W'(1);
        if (last_tap) begin
          state_nxt = S_D1;
        end else begin
          idx_nxt = idx_r + PTR_W'(1);
        end
      end
      S_D1: begin
        state_nxt = S_D2;
      end
      S_D2: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ctl.fin_en = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= fircb_pkg::TAP_RESET;
      pos_r       <= '0;
      hist_vld_r  <= '0;
      coef_vld_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_MAC);
      if (cfg_valid && cfg_ready) begin
        tap_r <= cfg_data;
      end
      if (acc_push) begin
        pos_r               <= pos_next;
        hist_vld_r[pos_eff] <= 1'b1;
      end else if (acc_clear) begin
        pos_r      <= '0;
        hist_vld_r <= '0;
      end
      if (acc_coef && cidx_ok) begin
        coef_vld_r[cidx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    idx_r  <= idx_nxt;
    hok_r  <= hist_vld_r[slot_r];
    cok_r  <= coef_vld_r[idx_r];
    if (out_load) begin
      out_data_r <= mac_res;
    end
  end

  assign smp_op  = hok_r ? $signed(hist_rdata) : '0;
  assign coef_op = cok_r ? $signed(coef_rdata) : '0;

  fircb_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (acc_push),
    .waddr (pos_eff),
    .wdata (in_data.sample_in),
    .raddr (slot_r),
    .rdata (hist_rdata)
  );

  fircb_ram #(
    .WIDTH (CB),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (acc_coef && cidx_ok),
    .waddr (cidx),
    .wdata (in_data.coef_value),
    .raddr (idx_r),
    .rdata (coef_rdata)
  );

  fircb_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .smp   (smp_op),
    .coef  (coef_op),
    .res_r (mac_res)
  );

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the done step");

  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (CNT_W'(idx_r) < taps))
    else $error("tap index past tap count");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (CNT_W'(slot_r) < taps))
    else $error("history slot past tap count");

  a_fin_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> $past(state_r == S_D2, 1) && !rd_vld_r)
    else $error("result taken before the accumulator drained");

endmodule
`default_nettype wire

FILE: sim/tb_fir_filter_circular_buffer_core.sv
`timescale 1ns / 1ps

module tb_fir_filter_circular_buffer_core;
  import fircb_pkg::*;

  localparam int NTAPS        = MAX_TAPS_DEF;
  localparam int IDX_W        = $clog2(NTAPS);
  localparam int DRAIN_CYCLES = NTAPS + 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 45;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  class fir_scoreboard;
    logic signed [SAMPLE_BITS-1:0] hist [NTAPS];
    logic signed [COEF_BITS-1:0]   coefs [NTAPS];
    int unsigned                   wpos;
    logic [TAP_CNT_W-1:0]          tap_reg;
    out_item_t                     expected_q [$];
    int                            errors;

    function new();
      foreach (hist[i]) begin
        hist[i]  = '0;
        coefs[i] = '0;
      end
      wpos    = 0;
      tap_reg = TAP_RESET;
      errors  = 0;
    endfunction

    function void set_taps(logic [TAP_CNT_W-1:0] v);
      tap_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(in_item_t it);
      int unsigned taps;
      int unsigned pos;
      int unsigned slot;
      int unsigned i;
      longint      acc;
      longint      shifted;
      out_item_t   res;
      case (it.op)
        OP_COEF: coefs[it.coef_index] = it.coef_value;
        OP_CLEAR: begin
          foreach (hist[k]) hist[k] = '0;
          wpos = 0;
        end
        OP_PUSH: begin
          if (tap_reg == 0) taps = 1;
          else if (tap_reg > NTAPS) taps = NTAPS;
          else taps = 32'(tap_reg);
          pos = (wpos < taps) ? wpos : 0;
          hist[IDX_W'(pos)] = it.sample_in;
          acc = 0;
          for (i = 0; i < taps; i++) begin
            slot = (pos >= i) ? (pos - i) : (pos + taps - i);
            acc += longint'(hist[IDX_W'(slot)]) * longint'(coefs[IDX_W'(i)]);
          end
          shifted = acc >>> FRAC_BITS;
          res.saturated = 1'b0;
          if (shifted > 32767) begin
            shifted = 32767;
            res.saturated = 1'b1;
          end else if (shifted < -32768) begin
            shifted = -32768;
            res.saturated = 1'b1;
          end
          res.filtered_out = shifted[SAMPLE_BITS-1:0];
          wpos = (pos + 1 >= taps) ? 0 : pos + 1;
          expected_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: out %0d sat %0b",
                         got.filtered_out, got.saturated));
      end else begin
        exp_item = expected_q.pop_front();
        if (got.filtered_out !== exp_item.filtered_out)
          report($sformatf("filtered_out got %0d exp %0d",
                           got.filtered_out, exp_item.filtered_out));
        if (got.saturated !== exp_item.saturated)
          report($sformatf("saturated got %0b exp %0b (out %0d)",
                           got.saturated, exp_item.saturated, exp_item.filtered_out));
      end
    endtask

    task flush_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [TAP_CNT_W-1:0] cfg_data;

  fir_scoreboard sb = new();
  bit            hold_req = 1'b0;
  int            burst_left = 0;
  bit            no_gaps = 1'b0;

  fir_filter_circular_buffer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t mk(logic [OP_W-1:0] op, logic [15:0] s,
                                  logic [4:0] idx, logic [15:0] c);
    in_item_t it;
    it.op         = op;
    it.sample_in  = s;
    it.coef_index = idx;
    it.coef_value = c;
    return it;
  endfunction

  function automatic logic [15:0] rand_word(bit modest);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 2) return (r == 0) ? 16'h7FFF : 16'h8000;
    if (r < 8) begin
      if (modest) return 16'($signed($urandom_range(0, 8191)) - 4096);
      return 16'($signed($urandom_range(0, 511)) - 256);
    end
    return 16'($urandom);
  endfunction

  function automatic in_item_t rand_item(int unsigned taps_eff);
    in_item_t    it;
    int unsigned r;
    it = mk(OP_PUSH, rand_word(1'b0), 5'($urandom), rand_word(1'b1));
    r = $urandom_range(0, 99);
    if (r < 72) it.op = OP_PUSH;
    else if (r < 90) begin
      it.op = OP_COEF;
      if ($urandom_range(0, 3) != 0) it.coef_index = 5'($urandom_range(0, taps_eff - 1));
    end else if (r < 95) it.op = OP_CLEAR;
    else it.op = OP_UNUSED;
    return it;
  endfunction

  // one beat on the input channel, with bursts and gaps ahead of it
  task send_item(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_taps(logic [TAP_CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_taps(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: runs of ready, stall and coin-flip, plus one long hold-off
  initial begin : rx_side
    int unsigned run_left;
    int unsigned mode;
    int unsigned hold_left;
    run_left  = 0;
    mode      = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode = $urandom_range(0, 2);
          run_left = (mode == 1) ? $urandom_range(1, 8) : $urandom_range(1, 60);
        end
        run_left--;
        out_ready <= (mode == 2) ? 1'($urandom_range(0, 1)) : (mode == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  initial begin : limit
    #5ms;
    $display("[fir_filter_circular_buffer_core] ERROR");
    $finish;
  end

  initial begin : main
    logic [TAP_CNT_W-1:0] tap_list [10];
    int unsigned          taps_eff;
    int unsigned          p;
    int unsigned          n;
    tap_list = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd7, 6'd2, 6'd31, 6'd16, 6'd33, 6'd5};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed, at the reset tap count
    send_item(mk(OP_PUSH,   16'h7FFF, 5'h1F, 16'hFFFF));
    send_item(mk(OP_COEF,   16'h0000, 5'd0,  16'h8000));
    send_item(mk(OP_PUSH,   16'h8000, 5'd0,  16'h0000));
    send_item(mk(OP_PUSH,   16'h7FFF, 5'd0,  16'h0000));
    send_item(mk(OP_COEF,   16'hFFFF, 5'd31, 16'h7FFF));
    send_item(mk(OP_COEF,   16'h0000, 5'd1,  16'h8000));
    send_item(mk(OP_PUSH,   16'h7FFF, 5'd0,  16'h0000));
    send_item(mk(OP_PUSH,   16'h8000, 5'h1F, 16'hFFFF));
    send_item(mk(OP_UNUSED, 16'hFFFF, 5'h1F, 16'hFFFF));
    send_item(mk(OP_PUSH,   16'h0000, 5'd0,  16'h0000));
    send_item(mk(OP_CLEAR,  16'hFFFF, 5'h1F, 16'hFFFF));
    send_item(mk(OP_PUSH,   16'h0001, 5'd0,  16'h0000));
    send_item(mk(OP_PUSH,   16'hFFFF, 5'd0,  16'h0000));
    send_item(mk(OP_COEF,   16'h0000, 5'd0,  16'h7FFF));
    send_item(mk(OP_COEF,   16'h0000, 5'd1,  16'h7FFF));
    send_item(mk(OP_PUSH,   16'h8000, 5'd0,  16'h0000));
    send_item(mk(OP_PUSH,   16'h8000, 5'd0,  16'h0000));
    send_item(mk(OP_PUSH,   16'h7FFF, 5'd0,  16'h0000));
    send_item(mk(OP_COEF,   16'h0000, 5'd0,  16'h0000));
    send_item(mk(OP_PUSH,   16'h1234, 5'd0,  16'h0000));
    send_item(mk(OP_UNUSED, 16'h0000, 5'd0,  16'h0000));

    foreach (tap_list[ph]) begin
      drain();
      write_taps(tap_list[ph]);
      if (tap_list[ph] == 0) taps_eff = 1;
      else if (tap_list[ph] > NTAPS) taps_eff = NTAPS;
      else taps_eff = 32'(tap_list[ph]);
      // mostly the documented sequence: clear, load taps, stream samples
      if ($urandom_range(0, 3) != 0) begin
        send_item(mk(OP_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom)));
        for (p = 0; p < taps_eff; p++) begin
          if ($urandom_range(0, 1) == 0)
            send_item(mk(OP_COEF, 16'($urandom), 5'(p), rand_word(1'b1)));
        end
      end
      no_gaps = (ph == 3);
      if (ph == 3) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(taps_eff));
    end

    drain();
    sb.flush_check();
    if (sb.errors == 0) begin
      $display("[fir_filter_circular_buffer_core] OK");
    end else begin
      $display("[fir_filter_circular_buffer_core] ERROR");
    end
    $finish;
  end

endmodule
